[design/ctb_pkg.sv]
// Shared definitions for the countdown timer bank: request and status codes,
// stream packing widths and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package ctb_pkg;

  // Default bank size and the report limit for one tick
  localparam int SLOTS_DEF   = 16;
  localparam int MAX_RESULTS = 16;
  localparam int RCNT_W      = $clog2(MAX_RESULTS + 1);

  // Stream payload widths
  localparam int IN_DATA_W  = 40;  // slot, timeout, zero fill
  localparam int IN_USER_W  = 4;   // req_type, timer_kind
  localparam int OUT_DATA_W = 40;  // status, result_slot, active_flag, tick_count, zero fill
  localparam int OUT_USER_W = 1;   // expired

  // Request codes
  typedef enum logic [2:0] {
    REQ_TICK   = 3'd0,
    REQ_CREATE = 3'd1,
    REQ_START  = 3'd2,
    REQ_STOP   = 3'd3,
    REQ_DELETE = 3'd4,
    REQ_QUERY  = 3'd5
  } ctb_req_t;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_NOFREE  = 2'd2
  } ctb_status_t;

  // Controller to datapath
  typedef struct packed {
    logic load_req;   // capture the input transfer
    logic tick_inc;   // advance the tick count, clear the expiry report
    logic scan_clr;   // slot pointer to zero
    logic scan_inc;   // slot pointer to next slot
    logic ram_rd;     // read period/remaining of the pointed slot
    logic do_single;  // execute start/stop/delete/query/unknown and emit its result
    logic do_create;  // claim the pointed slot and emit its result
    logic do_nofree;  // emit the no-free-slot result
    logic do_expire;  // write back the countdown of the pointed slot
    logic do_finish;  // emit the closing result of a tick
  } ctb_cmd_t;

  // Datapath to controller
  typedef struct packed {
    ctb_req_t req;        // captured request code
    logic     out_free;   // output register can take a result this cycle
    logic     scan_last;  // pointer at the highest slot
    logic     slot_elig;  // pointed slot allocated and active
    logic     slot_free;  // pointed slot not allocated
    logic     need_push;  // write-back would emit the held expiry
  } ctb_sts_t;

endpackage

`default_nettype wire

[design/countdown_timer_bank.sv]
// Top level of the countdown timer bank: controller plus datapath.
// Uses ctb_pkg, ctb_ctrl, ctb_datapath (and through it ctb_ram).
//
// Usage: requests arrive on the in_ stream, one transfer per request; results leave
// on the out_ stream, out_tlast marking the final result of each request.
// Non-tick requests give one result each, registered once the output register is free.
// A create walks the slots from the lowest upwards, one per cycle. A tick walks all
// slots: an idle slot is skipped, a running slot has its RAM read and then its
// countdown written back, between the entry in S_EXEC and the close in S_T_END.
// Expiries come out in ascending slot order; each is held until the next expiry
// or the close, so that the last can carry out_tlast. At most 16 expiries of one
// tick are reported; all slots are still updated.
// One request is in flight at a time; the next is taken in S_IDLE, entered once the
// current one has handed its final result to the output register, even if that
// result still waits.
// When the receiver stalls, the walk pauses at the next result that needs the
// output register. Synchronous reset frees all slots and clears the tick count;
// period/remaining storage needs no clearing pass, it is read only after a start.
`default_nettype none

module countdown_timer_bank #(
  parameter int SLOTS = ctb_pkg::SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [3:0] slot, [35:4] timeout, [39:36] zero
  input  wire logic [ctb_pkg::IN_DATA_W-1:0]  in_tdata,
  // [2:0] req_type, [3] timer_kind
  input  wire logic [ctb_pkg::IN_USER_W-1:0]  in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [1:0] status, [5:2] result_slot, [6] active_flag, [38:7] tick_count, [39] zero
  output logic      [ctb_pkg::OUT_DATA_W-1:0] out_tdata,
  // [0] expired
  output logic      [ctb_pkg::OUT_USER_W-1:0] out_tuser,
  output logic                                out_tlast
);

  import ctb_pkg::*;

  ctb_cmd_t cmd;
  ctb_sts_t sts;

  ctb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .cmd_o     (cmd),
    .sts_i     (sts)
  );

  ctb_datapath #(
    .SLOTS (SLOTS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );

endmodule

`default_nettype wire

[design/ctb_ram.sv]
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies.
`default_nettype none

module ctb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

[design/ctb_datapath.sv]
// Datapath of the timer bank: request capture, slot flags, period/remaining RAM,
// slot pointer, held expiry and the output register. Uses ctb_pkg and ctb_ram.
`default_nettype none

module ctb_datapath #(
  parameter int SLOTS = ctb_pkg::SLOTS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic [ctb_pkg::IN_DATA_W-1:0]    in_tdata,
  input  wire logic [ctb_pkg::IN_USER_W-1:0]    in_tuser,
  output logic                                  out_tvalid,
  input  wire logic                             out_tready,
  output logic      [ctb_pkg::OUT_DATA_W-1:0]   out_tdata,
  output logic      [ctb_pkg::OUT_USER_W-1:0]   out_tuser,
  output logic                                  out_tlast,
  input  wire ctb_pkg::ctb_cmd_t                cmd_i,
  output ctb_pkg::ctb_sts_t                     sts_o
);

  import ctb_pkg::*;

  localparam int IDXW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  // Captured request
  ctb_req_t    req_type_r;
  logic [3:0]  req_slot_r;
  logic        req_kind_r;
  logic [31:0] req_timeout_r;

  // Slot flags
  logic [SLOTS-1:0] alloc_r, alloc_nxt;
  logic [SLOTS-1:0] periodic_r, periodic_nxt;
  logic [SLOTS-1:0] active_r, active_nxt;

  logic [31:0]       elapsed_r;
  logic [IDXW-1:0]   scan_idx_r;
  logic              pend_valid_r;
  logic [3:0]        pend_slot_r;
  logic [RCNT_W-1:0] rep_cnt_r;

  // Output register
  logic        out_valid_r;
  ctb_status_t out_status_r;
  logic [3:0]  out_slot_r;
  logic        out_exp_r;
  logic        out_act_r;
  logic [31:0] out_ticks_r;
  logic        out_last_r;

  // RAM: {period, remaining} per slot
  logic            ram_we;
  logic [IDXW-1:0] ram_waddr;
  logic [63:0]     ram_wdata;
  logic [63:0]     ram_rdata;

  ctb_ram #(
    .WIDTH (64),
    .DEPTH (SLOTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (cmd_i.ram_rd),
    .raddr (scan_idx_r),
    .rdata (ram_rdata)
  );

  logic [IDXW-1:0] req_idx;
  logic            slot_ok;
  logic            start_ok;
  logic [31:0]     rd_rem, rd_per, dec_rem, new_rem;
  logic            expiring;
  logic            report;
  logic            out_free;

  assign req_idx  = IDXW'(req_slot_r);
  assign slot_ok  = {3'b000, req_slot_r} < 7'(SLOTS);
  assign start_ok = slot_ok && (req_timeout_r != 32'd0);
  assign rd_rem   = ram_rdata[31:0];
  assign rd_per   = ram_rdata[63:32];
  assign dec_rem  = rd_rem - 32'd1;
  assign expiring = (dec_rem == 32'd0);
  assign new_rem  = (expiring && periodic_r[scan_idx_r]) ? rd_per : dec_rem;
  assign report   = expiring && (rep_cnt_r < RCNT_W'(MAX_RESULTS));
  assign out_free = !out_valid_r || out_tready;

  // Status towards the controller
  assign sts_o.req       = req_type_r;
  assign sts_o.out_free  = out_free;
  assign sts_o.scan_last = (scan_idx_r == IDXW'(SLOTS - 1));
  assign sts_o.slot_elig = alloc_r[scan_idx_r] && active_r[scan_idx_r];
  assign sts_o.slot_free = !alloc_r[scan_idx_r];
  assign sts_o.need_push = report && pend_valid_r;

  // RAM write: countdown write-back or start
  assign ram_we    = cmd_i.do_expire || (cmd_i.do_single && (req_type_r == REQ_START) && start_ok);
  assign ram_waddr = cmd_i.do_expire ? scan_idx_r : req_idx;
  assign ram_wdata = cmd_i.do_expire ? {rd_per, new_rem} : {req_timeout_r, req_timeout_r};

  // Result of a single-result request
  ctb_status_t single_status;
  logic        single_act;

  always_comb begin
    single_status = ST_INVALID;
    single_act    = 1'b0;
    case (req_type_r)
      REQ_START: begin
        if (start_ok) single_status = ST_OK;
      end
      REQ_STOP, REQ_DELETE: begin
        if (slot_ok) single_status = ST_OK;
      end
      REQ_QUERY: begin
        if (slot_ok) begin
          single_status = ST_OK;
          single_act    = active_r[req_idx];
        end
      end
      default: begin
        single_status = ST_INVALID;
      end
    endcase
  end

  // Result selection
  logic        emit;
  ctb_status_t e_status;
  logic [3:0]  e_slot;
  logic        e_exp;
  logic        e_act;
  logic        e_last;

  always_comb begin
    emit     = 1'b0;
    e_status = ST_OK;
    e_slot   = 4'd0;
    e_exp    = 1'b0;
    e_act    = 1'b0;
    e_last   = 1'b1;
    if (cmd_i.do_single) begin
      emit     = 1'b1;
      e_status = single_status;
      e_act    = single_act;
    end else if (cmd_i.do_create) begin
      emit   = 1'b1;
      e_slot = 4'(scan_idx_r);
    end else if (cmd_i.do_nofree) begin
      emit     = 1'b1;
      e_status = ST_NOFREE;
    end else if (cmd_i.do_expire && report && pend_valid_r) begin
      // a later expiry exists, so the held one is not last
      emit   = 1'b1;
      e_slot = pend_slot_r;
      e_exp  = 1'b1;
      e_last = 1'b0;
    end else if (cmd_i.do_finish) begin
      emit = 1'b1;
      if (pend_valid_r) begin
        e_slot = pend_slot_r;
        e_exp  = 1'b1;
      end
    end
  end

  // Flag updates
  always_comb begin
    alloc_nxt    = alloc_r;
    periodic_nxt = periodic_r;
    active_nxt   = active_r;
    if (cmd_i.do_single && slot_ok) begin
      case (req_type_r)
        REQ_START: begin
          if (start_ok) active_nxt[req_idx] = 1'b1;
        end
        REQ_STOP: begin
          active_nxt[req_idx] = 1'b0;
        end
        REQ_DELETE: begin
          alloc_nxt[req_idx]    = 1'b0;
          periodic_nxt[req_idx] = 1'b0;
          active_nxt[req_idx]   = 1'b0;
        end
        default: begin
          active_nxt = active_r;
        end
      endcase
    end
    if (cmd_i.do_create) begin
      alloc_nxt[scan_idx_r]    = 1'b1;
      periodic_nxt[scan_idx_r] = req_kind_r;
      active_nxt[scan_idx_r]   = 1'b0;
    end
    if (cmd_i.do_expire && expiring && !periodic_r[scan_idx_r]) begin
      active_nxt[scan_idx_r] = 1'b0;
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd_i.load_req) begin
      req_type_r    <= ctb_req_t'(in_tuser[2:0]);
      req_kind_r    <= in_tuser[3];
      req_slot_r    <= in_tdata[3:0];
      req_timeout_r <= in_tdata[35:4];
    end
  end

  // Control state: flags, tick count, pointer, expiry report
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      alloc_r      <= '0;
      periodic_r   <= '0;
      active_r     <= '0;
      elapsed_r    <= 32'd0;
      scan_idx_r   <= '0;
      pend_valid_r <= 1'b0;
      rep_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      alloc_r    <= alloc_nxt;
      periodic_r <= periodic_nxt;
      active_r   <= active_nxt;
      if (cmd_i.tick_inc) begin
        elapsed_r    <= elapsed_r + 32'd1;
        pend_valid_r <= 1'b0;
        rep_cnt_r    <= '0;
      end
      if (cmd_i.scan_clr) begin
        scan_idx_r <= '0;
      end else if (cmd_i.scan_inc) begin
        scan_idx_r <= scan_idx_r + IDXW'(1);
      end
      if (cmd_i.do_expire && report) begin
        pend_valid_r <= 1'b1;
        rep_cnt_r    <= rep_cnt_r + RCNT_W'(1);
      end else if (cmd_i.do_finish) begin
        pend_valid_r <= 1'b0;
      end
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd_i.do_expire && report) begin
      pend_slot_r <= 4'(scan_idx_r);
    end
    if (emit) begin
      out_status_r <= e_status;
      out_slot_r   <= e_slot;
      out_exp_r    <= e_exp;
      out_act_r    <= e_act;
      out_ticks_r  <= elapsed_r;
      out_last_r   <= e_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {1'b0, out_ticks_r, out_act_r, out_slot_r, out_status_r};
  assign out_tuser  = out_exp_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    emit |-> out_free)
    else $error("result loaded while output register still occupied");

  a_rep_bound: assert property (@(posedge clk) disable iff (!rst_n)
    rep_cnt_r <= RCNT_W'(MAX_RESULTS))
    else $error("expiry report count beyond limit");

  a_pend_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r |-> (rep_cnt_r != '0))
    else $error("held expiry without a report count");

  a_create_claims: assert property (@(posedge clk) disable iff (!rst_n)
    cmd_i.do_create |=> ($countones(alloc_r) == $past($countones(alloc_r)) + 1))
    else $error("create did not claim exactly one slot");
`endif

endmodule

`default_nettype wire

[design/ctb_ctrl.sv]
// Controller of the timer bank: sequences request capture, the tick walk and the
// create search, and issues commands to the datapath. Uses ctb_pkg.
`default_nettype none

module ctb_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_tvalid,
  output logic                   in_tready,
  output ctb_pkg::ctb_cmd_t      cmd_o,
  input  wire ctb_pkg::ctb_sts_t sts_i
);

  import ctb_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_EXEC   = 6'b000010,
    S_T_CHK  = 6'b000100,
    S_T_EVAL = 6'b001000,
    S_T_END  = 6'b010000,
    S_C_SCAN = 6'b100000
  } ctb_state_t;

  ctb_state_t state_r, state_nxt;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd_o     = '0;
    in_tready = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd_o.load_req = 1'b1;
          state_nxt      = S_EXEC;
        end
      end
      S_EXEC: begin
        case (sts_i.req)
          REQ_TICK: begin
            cmd_o.tick_inc = 1'b1;
            cmd_o.scan_clr = 1'b1;
            state_nxt      = S_T_CHK;
          end
          REQ_CREATE: begin
            cmd_o.scan_clr = 1'b1;
            state_nxt      = S_C_SCAN;
          end
          default: begin
            if (sts_i.out_free) begin
              cmd_o.do_single = 1'b1;
              state_nxt       = S_IDLE;
            end
          end
        endcase
      end
      // skip idle slots, fetch counters of running ones
      S_T_CHK: begin
        if (sts_i.slot_elig) begin
          cmd_o.ram_rd = 1'b1;
          state_nxt    = S_T_EVAL;
        end else if (sts_i.scan_last) begin
          state_nxt = S_T_END;
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      // write back; wait only when a held expiry must go out
      S_T_EVAL: begin
        if (!sts_i.need_push || sts_i.out_free) begin
          cmd_o.do_expire = 1'b1;
          if (sts_i.scan_last) begin
            state_nxt = S_T_END;
          end else begin
            cmd_o.scan_inc = 1'b1;
            state_nxt      = S_T_CHK;
          end
        end
      end
      S_T_END: begin
        if (sts_i.out_free) begin
          cmd_o.do_finish = 1'b1;
          state_nxt       = S_IDLE;
        end
      end
      // lowest free slot, one slot per cycle
      S_C_SCAN: begin
        if (sts_i.slot_free) begin
          if (sts_i.out_free) begin
            cmd_o.do_create = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else if (sts_i.scan_last) begin
          if (sts_i.out_free) begin
            cmd_o.do_nofree = 1'b1;
            state_nxt       = S_IDLE;
          end
        end else begin
          cmd_o.scan_inc = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire
